// ----- rtl/tsc_pkg.sv -----
// tsc_pkg: shared types, constants and codes of the touch sample conditioner.
// Used by every module in rtl/; depends on nothing.
package tsc_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int COORD_W    = 16;
    localparam int SCALE_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int GROUP_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FLAGS_W    = 3;

    // Default filter shape
    localparam int DEF_SAMPLES_PER_READ = 5;
    localparam int DEF_TRIM_COUNT       = 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Group order is X1, Y1, X2, Y2; the fourth group closes a set
    localparam logic [GROUP_W-1:0] LAST_GROUP = 2'd3;
    localparam int                 PARTIALS   = 3;

    localparam logic [COORD_W-1:0] COORD_MAX = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAW_MODE        = 3'd0,
        CFG_SCREEN_CENTER_X = 3'd1,
        CFG_SCREEN_CENTER_Y = 3'd2,
        CFG_ADC_CENTER_X    = 3'd3,
        CFG_ADC_CENTER_Y    = 3'd4,
        CFG_X_SCALE         = 3'd5,
        CFG_Y_SCALE         = 3'd6,
        CFG_AGREE_LIMIT     = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic                       raw_mode;
        logic [SAMPLE_W-1:0]        screen_center_x;
        logic [SAMPLE_W-1:0]        screen_center_y;
        logic [SAMPLE_W-1:0]        adc_center_x;
        logic [SAMPLE_W-1:0]        adc_center_y;
        logic signed [SCALE_W-1:0]  x_scale;
        logic signed [SCALE_W-1:0]  y_scale;
        logic [SAMPLE_W-1:0]        agree_limit;
    } t_cfg;

    // Register values after reset
    localparam logic                      RST_RAW_MODE        = 1'b0;
    localparam logic [SAMPLE_W-1:0]       RST_SCREEN_CENTER_X = 12'd120;
    localparam logic [SAMPLE_W-1:0]       RST_SCREEN_CENTER_Y = 12'd160;
    localparam logic [SAMPLE_W-1:0]       RST_ADC_CENTER_X    = 12'd0;
    localparam logic [SAMPLE_W-1:0]       RST_ADC_CENTER_Y    = 12'd0;
    localparam logic signed [SCALE_W-1:0] RST_X_SCALE         = 24'sd65536;
    localparam logic signed [SCALE_W-1:0] RST_Y_SCALE         = 24'sd65536;
    localparam logic [SAMPLE_W-1:0]       RST_AGREE_LIMIT     = 12'd50;

    // Commands from the front to the back
    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_GROUP_END = 2'd1,
        CMD_PEN_UP    = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [GROUP_W-1:0]    group;
        logic [SAMPLE_W-1:0]   sample;
    } t_cmd;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SUM,
        BK_DIV,
        BK_MEAN,
        BK_MULT,
        BK_SAT,
        BK_EMIT
    } t_bk_state;

    // One result item
    typedef struct packed {
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
        logic               point_valid;
        logic               new_press;
        logic               pressed;
    } t_result;

endpackage

// ----- rtl/tsc_front.sv -----
// tsc_front: accepts input items, tracks slot and group, and issues commands.
// Depends on tsc_pkg; feeds tsc_queue.
module tsc_front import tsc_pkg::*; #(
    parameter int SAMPLES_PER_READ = DEF_SAMPLES_PER_READ
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_pen_down,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_full
);

    localparam int               SLOT_W    = $clog2(SAMPLES_PER_READ);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLES_PER_READ - 1);

    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [GROUP_W-1:0] r_group, n_group;
    logic               accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // Classify the item and advance the slot and group counters
    always_comb begin
        n_slot         = r_slot;
        n_group        = r_group;
        o_cmd.sample   = i_sample;
        o_cmd.group    = r_group;
        if (!i_pen_down) begin
            o_cmd.kind = CMD_PEN_UP;
            n_slot     = '0;
            n_group    = '0;
        end else if (r_slot == LAST_SLOT) begin
            o_cmd.kind = CMD_GROUP_END;
            n_slot     = '0;
            n_group    = r_group + 1'b1;
        end else begin
            o_cmd.kind = CMD_SAMPLE;
            n_slot     = r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_group <= '0;
        end else if (accept) begin
            r_slot  <= n_slot;
            r_group <= n_group;
        end
    end

endmodule

// ----- rtl/tsc_queue.sv -----
// tsc_queue: short command queue between the front and the back.
// Depends on tsc_pkg.
module tsc_queue import tsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/tsc_back.sv -----
// tsc_back: insertion-sorted sample row, trimmed mean, agreement check,
// screen conversion, press tracking and the output register. Depends on tsc_pkg.
module tsc_back import tsc_pkg::*; #(
    parameter int SAMPLES_PER_READ = DEF_SAMPLES_PER_READ,
    parameter int TRIM_COUNT       = DEF_TRIM_COUNT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int N        = SAMPLES_PER_READ;
    localparam int MAX_TRIM = (N - 1) / 2;
    localparam int TRIM_EFF = (TRIM_COUNT > MAX_TRIM) ? MAX_TRIM : TRIM_COUNT;
    localparam int KEEP     = N - 2 * TRIM_EFF;
    localparam int IDX_W    = $clog2(N);
    localparam int SUM_W    = SAMPLE_W + $clog2(KEEP);
    // Reciprocal of KEEP, exact floor for every sum below 2**SUM_W
    localparam int SHIFT    = SUM_W + 4;
    localparam int RECIP_W  = SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + KEEP - 1) / KEEP);
    localparam int DPROD_W  = SUM_W + RECIP_W;
    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(TRIM_EFF);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(N - TRIM_EFF - 1);
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = DIFF_W + SCALE_W;
    localparam int T_W      = PROD_W + 1;

    // Floor of t / 2**FRAC_W, clamped to the coordinate range
    function automatic logic [COORD_W-1:0] sat_coord(
        input logic signed [PROD_W-1:0] prod,
        input logic [SAMPLE_W-1:0]      center
    );
        logic signed [T_W-1:0] t;
        logic [COORD_W-1:0]    res;
        t = T_W'(prod) + $signed({{(T_W - SAMPLE_W - FRAC_W){1'b0}}, center, {FRAC_W{1'b0}}});
        if (t[T_W-1]) begin
            res = '0;
        end else if (|t[T_W-2:FRAC_W+COORD_W]) begin
            res = COORD_MAX;
        end else begin
            res = t[FRAC_W +: COORD_W];
        end
        return res;
    endfunction

    function automatic logic agree(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] range
    );
        logic [SAMPLE_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d < range;
    endfunction

    t_bk_state                 r_state, n_state;
    logic [SAMPLE_W-1:0]       r_row [N];
    logic [SAMPLE_W-1:0]       ins_row [N];
    logic                      gt [N];
    logic [IDX_W-1:0]          r_fill;
    logic [IDX_W-1:0]          r_idx;
    logic [GROUP_W-1:0]        r_group;
    logic [SUM_W-1:0]          r_sum;
    logic [DPROD_W-1:0]        r_dprod;
    logic [SAMPLE_W-1:0]       r_partial [PARTIALS];
    logic                      r_pt_valid;
    logic [SAMPLE_W-1:0]       r_ax, r_ay;
    logic signed [PROD_W-1:0]  r_px, r_py;
    logic [COORD_W-1:0]        r_cx, r_cy;
    logic                      r_pen_held;
    logic [COORD_W-1:0]        r_last_x, r_last_y, r_first_x, r_first_y;
    logic                      r_out_valid;
    t_result                   r_out;

    logic                      out_free;
    logic [SAMPLE_W-1:0]       mean;
    logic [SAMPLE_W:0]         sum_x, sum_y;
    logic signed [DIFF_W-1:0]  diff_x, diff_y;
    logic                      do_insert, do_close, do_pen_up, do_emit;
    logic [COORD_W-1:0]        pt_x, pt_y;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign mean     = r_dprod[SHIFT +: SAMPLE_W];

    // Insert the incoming sample into the sorted row; unfilled slots act as +inf
    always_comb begin
        for (int i = 0; i < N; i++) begin
            gt[i] = (i >= int'(r_fill)) || (r_row[i] > i_cmd.sample);
        end
        ins_row[0] = gt[0] ? i_cmd.sample : r_row[0];
        for (int i = 1; i < N; i++) begin
            if (!gt[i]) begin
                ins_row[i] = r_row[i];
            end else if (!gt[i-1]) begin
                ins_row[i] = i_cmd.sample;
            end else begin
                ins_row[i] = r_row[i-1];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && i_cmd.kind == CMD_GROUP_END) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                if (r_idx == IDX_LAST) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV:  n_state = BK_MEAN;
            BK_MEAN: n_state = (r_group == LAST_GROUP) ? BK_MULT : BK_IDLE;
            BK_MULT: n_state = BK_SAT;
            BK_SAT:  n_state = BK_EMIT;
            BK_EMIT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop     = 1'b0;
        do_insert = 1'b0;
        do_close  = 1'b0;
        do_pen_up = 1'b0;
        do_emit   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        CMD_SAMPLE: begin
                            o_pop     = 1'b1;
                            do_insert = 1'b1;
                        end
                        CMD_GROUP_END: begin
                            o_pop     = 1'b1;
                            do_insert = 1'b1;
                            do_close  = 1'b1;
                        end
                        CMD_PEN_UP: begin
                            o_pop     = out_free;
                            do_pen_up = out_free;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            BK_EMIT: do_emit = out_free;
            default: ;
        endcase
    end

    // Pair averages, conversion operands and the point being reported
    always_comb begin
        sum_x  = {1'b0, r_partial[0]} + {1'b0, r_partial[2]};
        sum_y  = {1'b0, r_partial[1]} + {1'b0, mean};
        diff_x = $signed({1'b0, r_ax}) - $signed({1'b0, i_cfg.adc_center_x});
        diff_y = $signed({1'b0, r_ay}) - $signed({1'b0, i_cfg.adc_center_y});
        pt_x   = r_pt_valid ? r_cx : r_last_x;
        pt_y   = r_pt_valid ? r_cy : r_last_y;
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            for (int i = 0; i < N; i++) begin
                r_row[i] <= ins_row[i];
            end
        end
        if (do_close) begin
            r_group <= i_cmd.group;
            r_idx   <= IDX_FIRST;
            r_sum   <= '0;
        end
        if (r_state == BK_SUM) begin
            r_sum <= r_sum + SUM_W'(r_row[r_idx]);
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == BK_DIV) begin
            r_dprod <= DPROD_W'(r_sum) * DPROD_W'(RECIP);
        end
        if (r_state == BK_MEAN) begin
            if (r_group == LAST_GROUP) begin
                r_pt_valid <= agree(r_partial[0], r_partial[2], i_cfg.agree_limit) &&
                              agree(r_partial[1], mean, i_cfg.agree_limit);
                r_ax       <= sum_x[SAMPLE_W:1];
                r_ay       <= sum_y[SAMPLE_W:1];
            end else begin
                r_partial[r_group] <= mean;
            end
        end
        if (r_state == BK_MULT) begin
            r_px <= PROD_W'(diff_x) * PROD_W'(i_cfg.x_scale);
            r_py <= PROD_W'(diff_y) * PROD_W'(i_cfg.y_scale);
        end
        if (r_state == BK_SAT) begin
            if (i_cfg.raw_mode) begin
                r_cx <= COORD_W'(r_ax);
                r_cy <= COORD_W'(r_ay);
            end else begin
                r_cx <= sat_coord(r_px, i_cfg.screen_center_x);
                r_cy <= sat_coord(r_py, i_cfg.screen_center_y);
            end
        end
        if (do_emit) begin
            r_out.pressed     <= 1'b1;
            r_out.new_press   <= !r_pen_held;
            r_out.point_valid <= r_pt_valid;
            r_out.pos_x       <= pt_x;
            r_out.pos_y       <= pt_y;
            r_out.first_x     <= r_pen_held ? r_first_x : pt_x;
            r_out.first_y     <= r_pen_held ? r_first_y : pt_y;
        end
        if (do_pen_up) begin
            r_out.pressed     <= 1'b0;
            r_out.new_press   <= 1'b0;
            r_out.point_valid <= 1'b0;
            r_out.pos_x       <= r_pen_held ? r_last_x : COORD_MAX;
            r_out.pos_y       <= r_pen_held ? r_last_y : COORD_MAX;
            r_out.first_x     <= r_pen_held ? r_first_x : '0;
            r_out.first_y     <= r_pen_held ? r_first_y : '0;
        end
    end

    // Control state, press tracking and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_fill      <= '0;
            r_pen_held  <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_close || do_pen_up) begin
                r_fill <= '0;
            end else if (do_insert) begin
                r_fill <= r_fill + 1'b1;
            end
            if (do_emit) begin
                r_last_x   <= pt_x;
                r_last_y   <= pt_y;
                r_pen_held <= 1'b1;
                if (!r_pen_held) begin
                    r_first_x <= pt_x;
                    r_first_y <= pt_y;
                end
            end
            if (do_pen_up) begin
                r_pen_held <= 1'b0;
                if (!r_pen_held) begin
                    r_last_x  <= COORD_MAX;
                    r_last_y  <= COORD_MAX;
                    r_first_x <= '0;
                    r_first_y <= '0;
                end
            end
            if (do_emit || do_pen_up) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/touch_sample_conditioner.sv -----
// touch_sample_conditioner: top level; holds the configuration registers and
// joins tsc_front, tsc_queue and tsc_back. Depends on tsc_pkg.
//
//   channel   | direction | tdata                         | tuser
//   ----------+-----------+-------------------------------+--------------------------------
//   s_axis    | in        | sample [11:0]                 | pen_down
//   m_axis    | out       | pos_x, pos_y, first_x, first_y| pressed, new_press, point_valid
//   cfg       | in        | i_cfg_index selects, i_cfg_data carries the value
//
// The front takes one item per cycle while the four-entry command queue has room.
// The back inserts each sample into the sorted row as it pops it while idle; the last
// sample of a group then starts the sum over the KEEP kept samples and the reciprocal
// multiply, and the last group of a set adds conversion and the result. It pops no
// further commands from the queue until it is back in BK_IDLE.
// Reset is synchronous and active low; no clearing pass is needed. A stalled
// m_axis holds one result in the output register while the queue keeps filling.
module touch_sample_conditioner import tsc_pkg::*; #(
    parameter int SAMPLES_PER_READ = DEF_SAMPLES_PER_READ,
    parameter int TRIM_COUNT       = DEF_TRIM_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [11:0] sample, [15:12] zero
    input  logic                  s_axis_tuser,   // [0] pen_down
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // pos_x, pos_y, first_x, first_y
    output logic [FLAGS_W-1:0]    m_axis_tuser    // pressed, new_press, point_valid
);

    t_cfg    r_cfg;
    t_cmd    push_cmd, pop_cmd;
    logic    push, pop, full, empty;
    t_result result;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_mode        <= RST_RAW_MODE;
            r_cfg.screen_center_x <= RST_SCREEN_CENTER_X;
            r_cfg.screen_center_y <= RST_SCREEN_CENTER_Y;
            r_cfg.adc_center_x    <= RST_ADC_CENTER_X;
            r_cfg.adc_center_y    <= RST_ADC_CENTER_Y;
            r_cfg.x_scale         <= RST_X_SCALE;
            r_cfg.y_scale         <= RST_Y_SCALE;
            r_cfg.agree_limit     <= RST_AGREE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RAW_MODE:        r_cfg.raw_mode        <= i_cfg_data[0];
                CFG_SCREEN_CENTER_X: r_cfg.screen_center_x <= i_cfg_data[SAMPLE_W-1:0];
                CFG_SCREEN_CENTER_Y: r_cfg.screen_center_y <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ADC_CENTER_X:    r_cfg.adc_center_x    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ADC_CENTER_Y:    r_cfg.adc_center_y    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_X_SCALE:         r_cfg.x_scale         <= $signed(i_cfg_data[SCALE_W-1:0]);
                CFG_Y_SCALE:         r_cfg.y_scale         <= $signed(i_cfg_data[SCALE_W-1:0]);
                CFG_AGREE_LIMIT:     r_cfg.agree_limit     <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    tsc_front #(
        .SAMPLES_PER_READ (SAMPLES_PER_READ)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pen_down (s_axis_tuser),
        .i_sample   (s_axis_tdata[SAMPLE_W-1:0]),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    tsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    tsc_back #(
        .SAMPLES_PER_READ (SAMPLES_PER_READ),
        .TRIM_COUNT       (TRIM_COUNT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_cmd    (pop_cmd),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Pack the result item
    assign m_axis_tdata = {result.first_y, result.first_x, result.pos_y, result.pos_x};
    assign m_axis_tuser = {result.point_valid, result.new_press, result.pressed};

endmodule
